/* rtl/core/hip_pkg.sv */
`default_nettype none

package hip_pkg;

    // Rows of the polynomial, one per power of temperature.
    localparam int ROWS = 4;

    // Width of the Horner accumulators for the row polynomials.
    localparam int CW = 56;

    // Width of the leading (RH cubed) coefficient of each row.
    localparam int TOPW = 32;

    typedef logic signed [CW-1:0]   t_acc;
    typedef logic signed [TOPW-1:0] t_top;

    // Row i holds the coefficients of RH^0, RH^1 and RH^2 scaled by 2^44, 2^48, 2^52, 2^60.
    localparam t_acc COEF [ROWS][3] = '{
        '{ 56'sd297712564429652,   56'sd94635581529192,   56'sd128229092234  },
        '{ 56'sd52132543386534,   -56'sd28218992315150,  -56'sd229393943245  },
        '{ 56'sd42410172510967,    56'sd1555417210504,    56'sd45982652915   },
        '{-56'sd44555804467036,    56'sd1645461100590,   -56'sd25183149133   }
    };

    // RH^3 coefficient of each row at the same scale as its row.
    localparam t_top COEF_TOP [ROWS] = '{
        32'sd512958238,
        32'sd55586523,
        32'sd3797868,
        -32'sd55567934
    };

    localparam logic signed [23:0] HI_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] HI_MIN = -24'sh800000;

endpackage

`default_nettype wire

/* rtl/core/heat_index_polynomial.sv */
// Throughput: one item per cycle unless the output stalls, set by the 13-stage
// pipeline in which each wide accumulator product is split into two partial
// products in one stage and summed in the next.
// Reset: synchronous, active low; it clears every stage valid bit, so the pipeline
// comes up empty. The data registers are not reset.
`default_nettype none

module heat_index_polynomial (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] temperature_f, [30:16] humidity_pct, [31] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [23:0] heat_index
    output logic        o_m_axis_tuser    // [0] saturated
);

    import hip_pkg::*;

    // Pipeline depth, counting the output register as the last stage.
    localparam int NST   = 13;
    localparam int TW    = 16;               // temperature width
    localparam int HW    = 15;               // humidity width
    localparam int SPLIT = 24;               // low-part width when splitting an accumulator
    localparam int M1W   = TOPW + HW + 1;    // leading coefficient times humidity
    localparam int PLW   = SPLIT + HW;       // low partial product in the row pipelines
    localparam int PHW   = CW - SPLIT + HW + 1;
    localparam int M7W   = 32 + TW + 1;      // scaled P3 times temperature
    localparam int QW    = CW - 12;          // P0 and P2 aligned to 2^-32 / 2^-40
    localparam int Q1W   = CW - 8;           // P1 aligned to 2^-40
    localparam int AW    = 44;               // A term, 2^-40 units
    localparam int BW    = 52;               // B and H terms
    localparam int TSPL  = 16;               // low-part width when splitting A and B
    localparam int TPLW  = TSPL + TW;
    localparam int TPHW  = AW - TSPL + TW + 1;

    // ------------------------------------------------------------------
    // Flow control. Each stage loads when it is empty or when the stage
    // after it moves on, so bubbles close up and an input transfer can
    // still happen while a finished result waits at the output.
    // ------------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || i_m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Input unpacking.
    logic [TW-1:0] w_t;
    logic [HW-1:0] w_h;

    assign w_t = i_s_axis_tdata[TW-1:0];
    assign w_h = i_s_axis_tdata[TW+HW-1:TW];

    // One Horner step after a split product: floor((hi*2^SPLIT + lo) * h / 2^8) + c.
    // The low product is non-negative, so only it needs the floor shift.
    function automatic t_acc f_row_add(input logic signed [PHW-1:0] ph,
                                       input logic [PLW-1:0] pl,
                                       input t_acc c);
        logic signed [63:0] v_sum;
        v_sum = (64'(ph) <<< (SPLIT - 8)) + $signed(64'(pl >> 8)) + 64'(c);
        return CW'(v_sum);
    endfunction

    // Same for the temperature terms: floor((hi*2^TSPL + lo) * t / 2^8) + q.
    function automatic logic signed [63:0] f_tail_add(input logic signed [TPHW-1:0] ph,
                                                      input logic [TPLW-1:0] pl,
                                                      input logic signed [63:0] q);
        logic signed [63:0] v_sum;
        v_sum = (64'(ph) <<< (TSPL - 8)) + $signed(64'(pl >> 8)) + q;
        return v_sum;
    endfunction

    // ------------------------------------------------------------------
    // Stages 1 to 6: the four row polynomials in humidity, side by side.
    // Each Horner step takes a multiply stage and an add stage.
    // ------------------------------------------------------------------
    logic signed [M1W-1:0] r1_m  [ROWS];
    logic signed [M1W-1:0] n1_m  [ROWS];
    t_acc                  r2_s  [ROWS];
    t_acc                  n2_s  [ROWS];
    logic [PLW-1:0]        r3_pl [ROWS];
    logic [PLW-1:0]        n3_pl [ROWS];
    logic signed [PHW-1:0] r3_ph [ROWS];
    logic signed [PHW-1:0] n3_ph [ROWS];
    t_acc                  r4_s  [ROWS];
    t_acc                  n4_s  [ROWS];
    logic [PLW-1:0]        r5_pl [ROWS];
    logic [PLW-1:0]        n5_pl [ROWS];
    logic signed [PHW-1:0] r5_ph [ROWS];
    logic signed [PHW-1:0] n5_ph [ROWS];
    t_acc                  r6_p  [ROWS];
    t_acc                  n6_p  [ROWS];

    logic [TW-1:0] r1_t, r2_t, r3_t, r4_t, r5_t, r6_t, r7_t, r8_t, r9_t, r10_t;
    logic [HW-1:0] r1_h, r2_h, r3_h, r4_h;

    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            n1_m[i]  = M1W'(COEF_TOP[i]) * M1W'($signed({1'b0, w_h}));
            n2_s[i]  = CW'(r1_m[i] >>> 8) + COEF[i][2];
            n3_pl[i] = {{HW{1'b0}}, r2_s[i][SPLIT-1:0]} * {{SPLIT{1'b0}}, r2_h};
            n3_ph[i] = PHW'($signed(r2_s[i][CW-1:SPLIT])) * PHW'($signed({1'b0, r2_h}));
            n4_s[i]  = f_row_add(r3_ph[i], r3_pl[i], COEF[i][1]);
            n5_pl[i] = {{HW{1'b0}}, r4_s[i][SPLIT-1:0]} * {{SPLIT{1'b0}}, r4_h};
            n5_ph[i] = PHW'($signed(r4_s[i][CW-1:SPLIT])) * PHW'($signed({1'b0, r4_h}));
            n6_p[i]  = f_row_add(r5_ph[i], r5_pl[i], COEF[i][0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_t <= w_t;
            r1_h <= w_h;
            r1_m <= n1_m;
        end
        if (w_en[1]) begin
            r2_t <= r1_t;
            r2_h <= r1_h;
            r2_s <= n2_s;
        end
        if (w_en[2]) begin
            r3_t  <= r2_t;
            r3_h  <= r2_h;
            r3_pl <= n3_pl;
            r3_ph <= n3_ph;
        end
        if (w_en[3]) begin
            r4_t <= r3_t;
            r4_h <= r3_h;
            r4_s <= n4_s;
        end
        if (w_en[4]) begin
            r5_t  <= r4_t;
            r5_pl <= n5_pl;
            r5_ph <= n5_ph;
        end
        if (w_en[5]) begin
            r6_t <= r5_t;
            r6_p <= n6_p;
        end
    end

    // ------------------------------------------------------------------
    // Stages 7 to 12: Horner in temperature over the row results.
    // A = P3*t + P2, B = A*t + P1, H = B*t + P0, each with its alignment.
    // ------------------------------------------------------------------
    logic signed [M7W-1:0]  r7_m,   n7_m;
    logic signed [QW-1:0]   r7_q2,  n7_q2;
    logic signed [Q1W-1:0]  r7_q1,  r8_q1, r9_q1, n7_q1;
    logic signed [QW-1:0]   r7_q0,  r8_q0, r9_q0, r10_q0, r11_q0, n7_q0;
    logic signed [AW-1:0]   r8_a,   n8_a;
    logic [TPLW-1:0]        r9_pl,  n9_pl;
    logic signed [TPHW-1:0] r9_ph,  n9_ph;
    logic signed [BW-1:0]   r10_b,  n10_b;
    logic [TPLW-1:0]        r11_pl, n11_pl;
    logic signed [TPHW-1:0] r11_ph, n11_ph;
    logic signed [BW-1:0]   r12_h,  n12_h;

    always_comb begin
        logic signed [63:0] v_a;
        logic signed [63:0] v_b;
        logic signed [63:0] v_h;
        logic signed [63:0] v_m;

        // P3 / 2^20 fits a signed 32-bit word.
        n7_m  = M7W'($signed(r6_p[3][51:20])) * M7W'($signed({1'b0, r6_t}));
        n7_q2 = $signed(r6_p[2][CW-1:12]);
        n7_q1 = $signed(r6_p[1][CW-1:8]);
        n7_q0 = $signed(r6_p[0][CW-1:12]);

        v_m  = 64'(r7_m) >>> 8;
        v_a  = v_m + 64'(r7_q2);
        n8_a = AW'(v_a);

        n9_pl = {{TW{1'b0}}, r8_a[TSPL-1:0]} * {{TSPL{1'b0}}, r8_t};
        n9_ph = TPHW'($signed(r8_a[AW-1:TSPL])) * TPHW'($signed({1'b0, r8_t}));

        v_b   = f_tail_add(r9_ph, r9_pl, 64'(r9_q1));
        n10_b = BW'(v_b);

        // B is taken down by 2^8 before its product with temperature.
        n11_pl = {{TW{1'b0}}, r10_b[TSPL+7:8]} * {{TSPL{1'b0}}, r10_t};
        n11_ph = TPHW'($signed(r10_b[BW-1:TSPL+8])) * TPHW'($signed({1'b0, r10_t}));

        v_h   = f_tail_add(r11_ph, r11_pl, 64'(r11_q0));
        n12_h = BW'(v_h);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_t  <= r6_t;
            r7_m  <= n7_m;
            r7_q2 <= n7_q2;
            r7_q1 <= n7_q1;
            r7_q0 <= n7_q0;
        end
        if (w_en[7]) begin
            r8_t  <= r7_t;
            r8_a  <= n8_a;
            r8_q1 <= r7_q1;
            r8_q0 <= r7_q0;
        end
        if (w_en[8]) begin
            r9_t  <= r8_t;
            r9_pl <= n9_pl;
            r9_ph <= n9_ph;
            r9_q1 <= r8_q1;
            r9_q0 <= r8_q0;
        end
        if (w_en[9]) begin
            r10_t  <= r9_t;
            r10_b  <= n10_b;
            r10_q0 <= r9_q0;
        end
        if (w_en[10]) begin
            r11_pl <= n11_pl;
            r11_ph <= n11_ph;
            r11_q0 <= r10_q0;
        end
        if (w_en[11]) begin
            r12_h <= n12_h;
        end
    end

    // ------------------------------------------------------------------
    // Stage 13: round half up to Q16.8, saturate, and hold the result in
    // the output register until the downstream side takes it.
    // ------------------------------------------------------------------
    logic [23:0] r_heat, n_heat;
    logic        r_sat,  n_sat;

    always_comb begin
        logic signed [63:0] v_r;
        v_r = (64'(r12_h) + 64'sd8388608) >>> 24;
        if (v_r > 64'(HI_MAX)) begin
            n_heat = HI_MAX;
            n_sat  = 1'b1;
        end else if (v_r < 64'(HI_MIN)) begin
            n_heat = HI_MIN;
            n_sat  = 1'b1;
        end else begin
            n_heat = v_r[23:0];
            n_sat  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[12]) begin
            r_heat <= n_heat;
            r_sat  <= n_sat;
        end
    end

    assign o_m_axis_tdata = r_heat;
    assign o_m_axis_tuser = r_sat;

endmodule

`default_nettype wire

/* rtl/core/hip_checker.sv */
`default_nettype none

module hip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    import hip_pkg::*;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // With the output free to move, the input side must be open.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input blocked although the output can drain");

    // A clipped result sits exactly at one end of the range.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            (o_m_axis_tdata == HI_MAX) || (o_m_axis_tdata == HI_MIN))
        else $error("saturation flag without a range-end value");

endmodule

bind heat_index_polynomial hip_checker u_hip_checker (.*);

`default_nettype wire
